[rtl/rgtc_pkg.sv]
// ----------------------------------------------------------------------------
// rgtc_pkg
// shared types, codes and key forming for the glyph tile cache
// ----------------------------------------------------------------------------
`default_nettype none

package rgtc_pkg;

    localparam int MAX_ROWS_DEF  = 8;
    localparam int SLOTS_PER_ROW = 16;
    localparam int ROWS_W        = 5;   // holds a row count up to sixteen
    localparam int KEY_W         = 16;
    localparam int COUNT_W       = 8;
    localparam int TILE_W        = 16;
    localparam int SLOT_OUT_W    = 7;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
    localparam logic [7:0]         CHAR_A    = 8'h61;
    localparam logic [7:0]         CHAR_Z    = 8'h7A;
    localparam logic [7:0]         PAIR_FLAG = 8'h40;
    localparam logic [TILE_W-1:0]  TILE_NONE = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_ACQUIRE = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_NOP     = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_NEW      = 3'd1,
        ST_FULL     = 3'd2,
        ST_RELEASED = 3'd3,
        ST_FREED    = 3'd4,
        ST_INVALID  = 3'd5,
        ST_CLEARED  = 3'd6,
        ST_SPARE    = 3'd7
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_TILE   = 2'd0,
        REG_ACTIVE_ROWS = 2'd1,
        REG_FONT_STYLE  = 2'd2,
        REG_SPARE       = 2'd3
    } reg_idx_t;

    typedef enum logic {
        ALU_INC = 1'b0,
        ALU_DEC = 1'b1
    } alu_op_t;

    // flags and updated count from the slot compare unit
    typedef struct packed {
        logic               match;
        logic               empty;
        logic               cnt_zero;
        logic               new_zero;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] new_count;
    } alu_res_t;

    // lowercase pairs fold into a compact key with a flag bit
    function automatic logic [KEY_W-1:0] make_key(input logic [7:0] f,
                                                   input logic [7:0] s,
                                                   input logic [3:0] style);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] hi;
        logic [7:0] lo;
        a = f - CHAR_A;
        b = s - CHAR_A;
        if (f >= CHAR_A && f <= CHAR_Z && s >= CHAR_A && s <= CHAR_Z) begin
            hi = {style, 4'b0000} | {6'b000000, a[4:3]} | PAIR_FLAG;
            lo = {a[2:0], b[4:0]};
        end else begin
            hi = {style, 4'b0000} | f;
            lo = s;
        end
        return {hi, lo};
    endfunction

endpackage

`default_nettype wire

[rtl/refcounted_glyph_tile_cache.sv]
// ----------------------------------------------------------------------------
// refcounted_glyph_tile_cache
// reference-counted tile slot cache keyed by a two-byte character code
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  s_        in    s_tvalid/s_tready  tuser: mode; tdata: first, second, tile
//  m_        out   m_tvalid/m_tready  tuser: status; tdata: tile_id, slot
//  cfg_      in    cfg_we             cfg_index, cfg_wdata (no read-back)
//
//  acquire walks the active slots one per cycle through the single read port
//  of the slot memory, across all rows*16 active slots on a miss, and stops
//  early when a match turns up in the walk
//  release reads the slot, then checks and updates it, then hands on the result; clear goes straight to the result
//  slot valid bits live in flip-flops, so reset and clear empty every slot at once
//  the result register lets the next beat in while a result waits on m_tready
//  aresetn is synchronous and active low
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_glyph_tile_cache #(
    parameter int MAX_ROWS = rgtc_pkg::MAX_ROWS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [1:0]                          s_tuser,  // mode
    input  wire logic [31:0]                         s_tdata,  // first, second, tile_number

    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [2:0]                               m_tuser,  // status
    output logic [23:0]                              m_tdata,  // tile_id, slot_index, pad

    input  wire logic                                cfg_we,
    input  wire logic [rgtc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rgtc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    import rgtc_pkg::*;

    localparam int NUM_SLOTS = MAX_ROWS * SLOTS_PER_ROW;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int LIMIT_W   = ROWS_W + 4;
    localparam int ENTRY_W   = KEY_W + COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REL_CHK,
        S_DONE
    } state_t;

    // ---- configuration registers
    logic [TILE_W-1:0] base_tile_reg;
    logic [3:0]        active_rows_reg;
    logic [3:0]        font_style_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_tile_reg   <= '0;
            active_rows_reg <= 4'd8;
            font_style_reg  <= '0;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_BASE_TILE:   base_tile_reg   <= cfg_wdata;
                REG_ACTIVE_ROWS: active_rows_reg <= cfg_wdata[3:0];
                REG_FONT_STYLE:  font_style_reg  <= cfg_wdata[3:0];
                default:         ;
            endcase
        end
    end

    // rows above the built size act as the built size
    logic [ROWS_W-1:0]  rows_use;
    logic [LIMIT_W-1:0] limit;

    assign rows_use = (ROWS_W'(active_rows_reg) > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS)
                                                                  : ROWS_W'(active_rows_reg);
    assign limit    = {rows_use, 4'b0000};

    function automatic logic [TILE_W-1:0] tile_of(input logic [TILE_W-1:0] base,
                                                   input logic [SLOT_W-1:0] idx);
        logic [TILE_W-1:0] row_part;
        logic [TILE_W-1:0] col_part;
        row_part = TILE_W'(idx >> 4) << 6;
        col_part = TILE_W'(idx[3:0]) << 1;
        return base + row_part + col_part;
    endfunction

    // ---- input beat decode
    logic              s_accept;
    mode_t             in_mode;
    logic [7:0]        in_first;
    logic [7:0]        in_second;
    logic [TILE_W-1:0] in_tile;
    logic [KEY_W-1:0]  in_key;
    logic [TILE_W-1:0] rel_d;
    logic [SLOT_W-1:0] rel_slot;
    logic              rel_row_bad;

    assign in_mode     = mode_t'(s_tuser);
    assign in_first    = s_tdata[7:0];
    assign in_second   = s_tdata[15:8];
    assign in_tile     = s_tdata[31:16];
    assign in_key      = make_key(in_first, in_second, font_style_reg);
    assign rel_d       = in_tile - base_tile_reg;
    // row is bits 15:6, column bits 4:1; the whole 2x2 block maps to one slot
    assign rel_slot    = SLOT_W'({rel_d[15:6], rel_d[4:1]});
    assign rel_row_bad = (rel_d[15:6] >= 10'(rows_use));

    // ---- sequencer registers
    state_t            state_reg,     state_next;
    logic [KEY_W-1:0]  key_reg,       key_next;
    logic [TILE_W-1:0] tile_in_reg,   tile_in_next;
    logic [CNT_W-1:0]  scan_idx_reg,  scan_idx_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0] cmp_idx_reg,   cmp_idx_next;
    logic              have_free_reg, have_free_next;
    logic [SLOT_W-1:0] free_idx_reg,  free_idx_next;
    logic [NUM_SLOTS-1:0] valid_reg,  valid_next;
    status_t           res_status_reg, res_status_next;
    logic [TILE_W-1:0] res_tile_reg,  res_tile_next;
    logic [SLOT_W-1:0] res_slot_reg,  res_slot_next;
    logic              m_tvalid_reg,  m_tvalid_next;
    status_t           m_status_reg,  m_status_next;
    logic [TILE_W-1:0] m_tile_reg,    m_tile_next;
    logic [SLOT_OUT_W-1:0] m_slot_reg, m_slot_next;

    // ---- slot memory and compare unit
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [SLOT_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    alu_op_t            alu_op;
    alu_res_t           alu_res;

    rgtc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rgtc_alu u_alu (
        .entry_valid (valid_reg[cmp_idx_reg]),
        .rd_key      (ram_rdata[ENTRY_W-1:COUNT_W]),
        .rd_count    (ram_rdata[COUNT_W-1:0]),
        .search_key  (key_reg),
        .op          (alu_op),
        .res         (alu_res)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        state_next      = state_reg;
        key_next        = key_reg;
        tile_in_next    = tile_in_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        have_free_next  = have_free_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        res_status_next = res_status_reg;
        res_tile_next   = res_tile_reg;
        res_slot_next   = res_slot_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_status_next   = m_status_reg;
        m_tile_next     = m_tile_reg;
        m_slot_next     = m_slot_reg;
        ram_we          = 1'b0;
        ram_waddr       = cmp_idx_reg;
        ram_wdata       = {key_reg, alu_res.new_count};
        ram_re          = 1'b0;
        ram_raddr       = scan_idx_reg[SLOT_W-1:0];
        alu_op          = ALU_INC;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    key_next     = in_key;
                    tile_in_next = in_tile;
                    unique case (in_mode)
                        MODE_ACQUIRE: begin
                            if (in_key == '0) begin
                                // a zero key cannot be stored
                                res_status_next = ST_FULL;
                                res_tile_next   = TILE_NONE;
                                res_slot_next   = '0;
                                state_next      = S_DONE;
                            end else begin
                                scan_idx_next  = '0;
                                cmp_valid_next = 1'b0;
                                have_free_next = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        MODE_RELEASE: begin
                            if (rel_row_bad) begin
                                res_status_next = ST_INVALID;
                                res_tile_next   = in_tile;
                                res_slot_next   = '0;
                                state_next      = S_DONE;
                            end else begin
                                ram_re       = 1'b1;
                                ram_raddr    = rel_slot;
                                cmp_idx_next = rel_slot;
                                state_next   = S_REL_CHK;
                            end
                        end
                        MODE_CLEAR: begin
                            valid_next      = '0;
                            res_status_next = ST_CLEARED;
                            res_tile_next   = '0;
                            res_slot_next   = '0;
                            state_next      = S_DONE;
                        end
                        default: ;
                    endcase
                end
            end

            S_SCAN: begin
                alu_op = ALU_INC;
                if (cmp_valid_reg && alu_res.match) begin
                    ram_we          = 1'b1;
                    ram_waddr       = cmp_idx_reg;
                    ram_wdata       = {key_reg, alu_res.new_count};
                    res_status_next = ST_HIT;
                    res_tile_next   = tile_of(base_tile_reg, cmp_idx_reg);
                    res_slot_next   = cmp_idx_reg;
                    state_next      = S_DONE;
                end else begin
                    if (cmp_valid_reg && alu_res.empty && !have_free_reg) begin
                        have_free_next = 1'b1;
                        free_idx_next  = cmp_idx_reg;
                    end
                    if (LIMIT_W'(scan_idx_reg) < limit) begin
                        ram_re         = 1'b1;
                        ram_raddr      = scan_idx_reg[SLOT_W-1:0];
                        cmp_valid_next = 1'b1;
                        cmp_idx_next   = scan_idx_reg[SLOT_W-1:0];
                        scan_idx_next  = scan_idx_reg + 1'b1;
                    end else begin
                        cmp_valid_next = 1'b0;
                        if (!cmp_valid_reg) begin
                            if (have_free_reg) begin
                                ram_we                  = 1'b1;
                                ram_waddr               = free_idx_reg;
                                ram_wdata               = {key_reg, COUNT_W'(1)};
                                valid_next[free_idx_reg] = 1'b1;
                                res_status_next         = ST_NEW;
                                res_tile_next   = tile_of(base_tile_reg, free_idx_reg);
                                res_slot_next           = free_idx_reg;
                            end else begin
                                res_status_next = ST_FULL;
                                res_tile_next   = TILE_NONE;
                                res_slot_next   = '0;
                            end
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_REL_CHK: begin
                alu_op = ALU_DEC;
                if (alu_res.cnt_zero) begin
                    res_status_next = ST_INVALID;
                    res_tile_next   = tile_in_reg;
                end else if (alu_res.new_zero) begin
                    valid_next[cmp_idx_reg] = 1'b0;
                    res_status_next         = ST_FREED;
                    res_tile_next           = tile_of(base_tile_reg, cmp_idx_reg);
                end else begin
                    ram_we          = 1'b1;
                    ram_waddr       = cmp_idx_reg;
                    ram_wdata       = {alu_res.key, alu_res.new_count};
                    res_status_next = ST_RELEASED;
                    res_tile_next   = tile_of(base_tile_reg, cmp_idx_reg);
                end
                res_slot_next = cmp_idx_reg;
                state_next    = S_DONE;
            end

            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_tile_next   = res_tile_reg;
                    m_slot_next   = SLOT_OUT_W'(res_slot_reg);
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cmp_valid_reg <= 1'b0;
            have_free_reg <= 1'b0;
            valid_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            have_free_reg <= have_free_next;
            valid_reg     <= valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        key_reg        <= key_next;
        tile_in_reg    <= tile_in_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        free_idx_reg   <= free_idx_next;
        res_status_reg <= res_status_next;
        res_tile_reg   <= res_tile_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_tile_reg     <= m_tile_next;
        m_slot_reg     <= m_slot_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {1'b0, m_slot_reg, m_tile_reg};

    // ---- checks

    // the scan pointer never runs past the active slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (LIMIT_W'(scan_idx_reg) <= limit))
        else $error("scan pointer beyond active slots");

    // slot memory is only written while an item is being worked on
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_SCAN || state_reg == S_REL_CHK))
        else $error("slot write outside a scan or release");

    // a clear empties every slot at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_mode == MODE_CLEAR) |=> (valid_reg == '0))
        else $error("slots left valid after clear");

    // a full answer carries no tile and slot zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_status_reg == ST_FULL) |->
            (m_tile_reg == TILE_NONE && m_slot_reg == '0))
        else $error("full result with a tile attached");

    // the result register is never overwritten while a beat waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && $stable(m_tile_reg)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

[rtl/rgtc_ram.sv]
// ----------------------------------------------------------------------------
// rgtc_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rgtc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/rgtc_alu.sv]
// ----------------------------------------------------------------------------
// rgtc_alu
// shared slot compare unit: key match, empty test and count step
// ----------------------------------------------------------------------------
`default_nettype none

module rgtc_alu (
    input  wire logic                           entry_valid,
    input  wire logic [rgtc_pkg::KEY_W-1:0]     rd_key,
    input  wire logic [rgtc_pkg::COUNT_W-1:0]   rd_count,
    input  wire logic [rgtc_pkg::KEY_W-1:0]     search_key,
    input  wire rgtc_pkg::alu_op_t              op,
    output rgtc_pkg::alu_res_t                  res
);

    import rgtc_pkg::*;

    logic [KEY_W-1:0]   key_eff;
    logic [COUNT_W-1:0] cnt_eff;

    // an entry whose valid bit is clear (never written since reset or clear, or freed) reads as empty
    assign key_eff = entry_valid ? rd_key : '0;
    assign cnt_eff = entry_valid ? rd_count : '0;

    always_comb begin
        res          = '0;
        res.key      = key_eff;
        res.match    = (key_eff == search_key);
        res.empty    = (key_eff == '0);
        res.cnt_zero = (cnt_eff == '0);
        unique case (op)
            ALU_INC: res.new_count = (cnt_eff == COUNT_MAX) ? COUNT_MAX
                                                           : cnt_eff + 1'b1;
            ALU_DEC: res.new_count = cnt_eff - 1'b1;
            default: res.new_count = cnt_eff;
        endcase
        res.new_zero = (res.new_count == '0);
    end

endmodule

`default_nettype wire
